>>> design/double_ended_queue_top_assert.svh
// Assertion macros for the double-ended queue checker.
// Used by dec_chk; needs clk_i and rst_ni in scope.
`ifndef DOUBLE_ENDED_QUEUE_TOP_ASSERT_SVH
`define DOUBLE_ENDED_QUEUE_TOP_ASSERT_SVH

// Same-cycle implication, masked during reset
`define DEC_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, masked during reset
`define DEC_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> design/dec_pkg.sv
// Shared types and constants for the double-ended queue.
// No dependencies; imported by double_ended_queue_top, dec_chk and the testbench.
package dec_pkg;

  localparam int unsigned WordW = 32;
  localparam int unsigned OccW  = 5;

  typedef enum logic [1:0] {
    FUNC_PUSH_FRONT = 2'd0,
    FUNC_PUSH_BACK  = 2'd1,
    FUNC_POP_FRONT  = 2'd2,
    FUNC_POP_BACK   = 2'd3
  } dec_func_e;

  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_OVERFLOW  = 2'd1,
    ST_UNDERFLOW = 2'd2
  } dec_status_e;

  typedef enum logic {
    FSM_IDLE,
    FSM_READ
  } dec_fsm_e;

  typedef struct packed {
    dec_func_e                func;
    logic signed [WordW-1:0]  push_value;
  } dec_in_t;

  typedef struct packed {
    dec_status_e              status;
    logic signed [WordW-1:0]  popped_value;
    logic [OccW-1:0]          occupancy;
  } dec_out_t;

endpackage

>>> design/double_ended_queue_top.sv
// Double-ended queue: words in a circular RAM, head index and count in flops.
// Push or refused op: result next cycle. Good pop: via RAM read reg, then output register.
// Throughput: one push per cycle unless stalled; no beat taken while a pop waits on the RAM.
// A new beat is taken only when the output register is empty or its beat leaves that cycle.
// Reset (async, active low) clears head, count, FSM and output valid.
// The RAM is not cleared; no entry is read before a push writes it.
module double_ended_queue_top
  import dec_pkg::*;
#(
  parameter int unsigned DEPTH = 16
) (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     in_valid_i,
  output logic     in_stall_o,
  input  dec_in_t  in_data_i,
  output logic     out_valid_o,
  input  logic     out_stall_i,
  output dec_out_t out_data_o
);

  localparam int unsigned AW = $clog2(DEPTH);
  localparam int unsigned CW = $clog2(DEPTH + 1);
  localparam int unsigned SW = AW + 1;
  localparam logic [AW-1:0] LastIdx = AW'(DEPTH - 1);
  localparam logic [SW-1:0] DepthS  = SW'(DEPTH);
  localparam logic [CW-1:0] DepthC  = CW'(DEPTH);

  dec_fsm_e        state_q, state_d;
  logic [AW-1:0]   head_q, head_d;
  logic [CW-1:0]   count_q, count_d;
  logic            out_valid_q, out_valid_d;
  dec_out_t        out_q, out_d;

  logic            in_fire;
  logic            is_pop;
  logic            full;
  logic            empty;
  logic [SW-1:0]   back_sum;
  logic [SW-1:0]   back_sum_m1;
  logic [AW-1:0]   back_slot;
  logic [AW-1:0]   last_slot;
  logic [AW-1:0]   front_prev;
  logic [AW-1:0]   head_next;
  logic [CW+OccW-1:0] occ_ext;

  logic            ram_we;
  logic [AW-1:0]   ram_waddr;
  logic            ram_re;
  logic [AW-1:0]   ram_raddr;
  logic [WordW-1:0] ram_rdata;

  assign in_fire = in_valid_i && !in_stall_o;
  assign is_pop  = (in_data_i.func == FUNC_POP_FRONT) || (in_data_i.func == FUNC_POP_BACK);
  assign full    = (count_q == DepthC);
  assign empty   = (count_q == '0);

  // Circular index arithmetic, one compare-and-wrap each
  assign back_sum    = SW'(head_q) + SW'(count_q);
  assign back_sum_m1 = back_sum - SW'(1);
  assign back_slot   = (back_sum >= DepthS) ? AW'(back_sum - DepthS) : AW'(back_sum);
  assign last_slot   = (back_sum_m1 >= DepthS) ? AW'(back_sum_m1 - DepthS) : AW'(back_sum_m1);
  assign front_prev  = (head_q == '0) ? LastIdx : head_q - AW'(1);
  assign head_next   = (head_q == LastIdx) ? '0 : head_q + AW'(1);

  // Next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      FSM_IDLE: begin
        if (in_fire && is_pop && !empty) begin
          state_d = FSM_READ;
        end
      end
      FSM_READ: begin
        state_d = FSM_IDLE;
      end
      default: state_d = FSM_IDLE;
    endcase
  end

  // Datapath control and result build
  always_comb begin
    in_stall_o  = (state_q != FSM_IDLE) || (out_valid_q && out_stall_i);
    head_d      = head_q;
    count_d     = count_q;
    out_valid_d = out_valid_q && out_stall_i;
    out_d       = out_q;
    ram_we      = 1'b0;
    ram_waddr   = back_slot;
    ram_re      = 1'b0;
    ram_raddr   = head_q;
    occ_ext     = '0;
    unique case (state_q)
      FSM_IDLE: begin
        if (in_fire) begin
          out_d.status       = ST_OK;
          out_d.popped_value = '0;
          out_valid_d        = 1'b1;
          unique case (in_data_i.func) inside
            FUNC_PUSH_FRONT, FUNC_PUSH_BACK: begin
              if (full) begin
                out_d.status = ST_OVERFLOW;
              end else begin
                ram_we  = 1'b1;
                count_d = count_q + CW'(1);
                if (in_data_i.func == FUNC_PUSH_FRONT) begin
                  ram_waddr = front_prev;
                  head_d    = front_prev;
                end
              end
            end
            FUNC_POP_FRONT, FUNC_POP_BACK: begin
              if (empty) begin
                out_d.status = ST_UNDERFLOW;
              end else begin
                // popped word lands from the RAM next cycle
                ram_re      = 1'b1;
                out_valid_d = 1'b0;
                count_d     = count_q - CW'(1);
                if (in_data_i.func == FUNC_POP_FRONT) begin
                  head_d = head_next;
                end else begin
                  ram_raddr = last_slot;
                end
              end
            end
            default: ;
          endcase
          occ_ext         = {{OccW{1'b0}}, count_d};
          out_d.occupancy = occ_ext[OccW-1:0];
        end
      end
      FSM_READ: begin
        out_d.popped_value = ram_rdata;
        out_valid_d        = 1'b1;
      end
      default: ;
    endcase
  end

  // Control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= FSM_IDLE;
      head_q      <= '0;
      count_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      head_q      <= head_d;
      count_q     <= count_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Result payload register
  always_ff @(posedge clk_i) begin
    out_q <= out_d;
  end

  dec_ram #(
    .Width (WordW),
    .Depth (DEPTH)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (in_data_i.push_value),
    .re_i    (ram_re),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

endmodule

>>> design/dec_ram.sv
// Generic single-clock RAM, one write and one read port, registered read.
// No package dependencies.
module dec_ram #(
  parameter int unsigned Width = 32,
  parameter int unsigned Depth = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  // Write port and registered read port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

>>> design/dec_chk.sv
// Port-level checker for the double-ended queue, bound to the top level.
// Depends on dec_pkg and double_ended_queue_top_assert.svh.
`include "double_ended_queue_top_assert.svh"

module dec_chk
  import dec_pkg::*;
#(
  parameter int unsigned DEPTH = 16
) (
  input logic     clk_i,
  input logic     rst_ni,
  input logic     in_valid_i,
  input logic     in_stall_o,
  input dec_in_t  in_data_i,
  input logic     out_valid_o,
  input logic     out_stall_i,
  input dec_out_t out_data_o
);

  localparam logic [OccW-1:0] DepthOcc = OccW'(DEPTH);

  logic res_held;
  logic push_fire;
  logic ovf_seen;
  logic ovf_shape;
  logic unf_seen;
  logic unf_shape;

  // Port-level terms used below
  assign res_held  = out_valid_o && out_stall_i;
  assign push_fire = in_valid_i && !in_stall_o &&
                     (in_data_i.func == FUNC_PUSH_FRONT || in_data_i.func == FUNC_PUSH_BACK);
  assign ovf_seen  = out_valid_o && (out_data_o.status == ST_OVERFLOW);
  assign ovf_shape = (out_data_o.occupancy == DepthOcc) && (out_data_o.popped_value == '0);
  assign unf_seen  = out_valid_o && (out_data_o.status == ST_UNDERFLOW);
  assign unf_shape = (out_data_o.occupancy == '0) && (out_data_o.popped_value == '0);

  // A stalled result beat holds
  `DEC_ASSERT_NEXT(a_hold, res_held, out_valid_o && $stable(out_data_o), "held beat moved")

  // Refused push reports a full queue and no word
  `DEC_ASSERT_NOW(a_overflow, ovf_seen, ovf_shape, "bad overflow result")

  // Empty pop reports an empty queue and no word
  `DEC_ASSERT_NOW(a_underflow, unf_seen, unf_shape, "bad underflow result")

  // Any accepted push shows its result on the next cycle
  `DEC_ASSERT_NEXT(a_push_result, push_fire, out_valid_o, "push gave no result")

  // No input beat is taken while a result is held off
  `DEC_ASSERT_NOW(a_in_blocked, res_held, in_stall_o, "input taken while result held")

endmodule

bind double_ended_queue_top dec_chk #(.DEPTH(DEPTH)) u_dec_chk (.*);

>>> test/double_ended_queue_top_tb.sv
// Self-checking testbench for double_ended_queue_top: directed table, then biased random ops.
// Expected results come from a behavioral deque model kept in this file.
// Depends on dec_pkg and the double_ended_queue_top RTL.
module double_ended_queue_top_tb;
  import dec_pkg::*;

  localparam int unsigned Depth      = 16;
  localparam int          CycleLimit = 200_000;
  localparam int          RandomOps  = 1550;
  localparam int          DirRows    = 27;

  // One row of the directed table; typed-in result used only where marked
  typedef struct {
    dec_func_e     func;
    logic [31:0]   value;
    bit            typed;
    dec_status_e   st;
    logic [31:0]   popped;
    logic [4:0]    occ;
  } dir_row_t;

  logic     clk_i       = 1'b0;
  logic     rst_ni      = 1'b0;
  logic     in_valid_i  = 1'b0;
  logic     in_stall_o;
  dec_in_t  in_data_i   = '0;
  logic     out_valid_o;
  logic     out_stall_i = 1'b0;
  dec_out_t out_data_o;

  // Deque model state
  logic [31:0] dq_store [Depth];
  logic [3:0]  dq_head  = '0;
  logic [4:0]  dq_count = '0;

  dec_out_t exp_results [$];
  int       errors      = 0;
  int       cycles      = 0;
  bit       quiet_run   = 1'b0;
  bit       hold_req    = 1'b0;
  int       hold_cycles = 0;

  dir_row_t dir_rows [DirRows] = '{
    // empty queue: both pops underflow
    '{FUNC_POP_FRONT,  32'h0000_0000, 1'b1, ST_UNDERFLOW, 32'h0000_0000, 5'd0},
    '{FUNC_POP_BACK,   32'hFFFF_FFFF, 1'b1, ST_UNDERFLOW, 32'h0000_0000, 5'd0},
    // extremes in and out again
    '{FUNC_PUSH_FRONT, 32'h8000_0000, 1'b1, ST_OK,        32'h0000_0000, 5'd1},
    '{FUNC_PUSH_BACK,  32'h7FFF_FFFF, 1'b1, ST_OK,        32'h0000_0000, 5'd2},
    '{FUNC_POP_FRONT,  32'h0000_0000, 1'b1, ST_OK,        32'h8000_0000, 5'd1},
    '{FUNC_POP_BACK,   32'h0000_0000, 1'b1, ST_OK,        32'h7FFF_FFFF, 5'd0},
    // empty again, head back at zero
    '{FUNC_POP_BACK,   32'h1234_5678, 1'b1, ST_UNDERFLOW, 32'h0000_0000, 5'd0},
    // fill to the brim from both ends
    '{FUNC_PUSH_FRONT, 32'hFFFF_FFFF, 1'b0, ST_OK, '0, '0},
    '{FUNC_PUSH_BACK,  32'h0000_0000, 1'b0, ST_OK, '0, '0},
    '{FUNC_PUSH_FRONT, 32'h0000_0001, 1'b0, ST_OK, '0, '0},
    '{FUNC_PUSH_BACK,  32'hFFFF_FFFE, 1'b0, ST_OK, '0, '0},
    '{FUNC_PUSH_FRONT, 32'h5555_5555, 1'b0, ST_OK, '0, '0},
    '{FUNC_PUSH_BACK,  32'hAAAA_AAAA, 1'b0, ST_OK, '0, '0},
    '{FUNC_PUSH_FRONT, 32'h1234_5678, 1'b0, ST_OK, '0, '0},
    '{FUNC_PUSH_BACK,  32'h8765_4321, 1'b0, ST_OK, '0, '0},
    '{FUNC_PUSH_FRONT, 32'h0000_FFFF, 1'b0, ST_OK, '0, '0},
    '{FUNC_PUSH_BACK,  32'hFFFF_0000, 1'b0, ST_OK, '0, '0},
    '{FUNC_PUSH_FRONT, 32'h7FFF_FFFF, 1'b0, ST_OK, '0, '0},
    '{FUNC_PUSH_BACK,  32'h8000_0000, 1'b0, ST_OK, '0, '0},
    '{FUNC_PUSH_FRONT, 32'h00FF_00FF, 1'b0, ST_OK, '0, '0},
    '{FUNC_PUSH_BACK,  32'hFF00_FF00, 1'b0, ST_OK, '0, '0},
    '{FUNC_PUSH_FRONT, 32'h0F0F_0F0F, 1'b0, ST_OK, '0, '0},
    '{FUNC_PUSH_BACK,  32'hF0F0_F0F0, 1'b0, ST_OK, '0, '0},
    // full: both pushes refused
    '{FUNC_PUSH_BACK,  32'h0BAD_0BAD, 1'b1, ST_OVERFLOW,  32'h0000_0000, 5'd16},
    '{FUNC_PUSH_FRONT, 32'hDEAD_0001, 1'b1, ST_OVERFLOW,  32'h0000_0000, 5'd16},
    '{FUNC_POP_BACK,   32'h0000_0000, 1'b0, ST_OK, '0, '0},
    '{FUNC_POP_FRONT,  32'h0000_0000, 1'b0, ST_OK, '0, '0}
  };

  double_ended_queue_top #(
    .DEPTH(Depth)
  ) dut (
    .clk_i,
    .rst_ni,
    .in_valid_i,
    .in_stall_o,
    .in_data_i,
    .out_valid_o,
    .out_stall_i,
    .out_data_o
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // Apply one operation to the model deque and return its result
  function automatic dec_out_t deque_step(input dec_in_t op);
    dec_out_t   r;
    logic [3:0] slot;
    r.status       = ST_OK;
    r.popped_value = '0;
    if (op.func == FUNC_PUSH_FRONT || op.func == FUNC_PUSH_BACK) begin
      if (dq_count >= Depth) begin
        r.status = ST_OVERFLOW;
      end else if (op.func == FUNC_PUSH_FRONT) begin
        dq_head = dq_head - 4'd1;
        dq_store[dq_head] = op.push_value;
        dq_count++;
      end else begin
        slot = dq_head + dq_count[3:0];
        dq_store[slot] = op.push_value;
        dq_count++;
      end
    end else begin
      if (dq_count == 0) begin
        r.status = ST_UNDERFLOW;
      end else if (op.func == FUNC_POP_FRONT) begin
        r.popped_value = dq_store[dq_head];
        dq_head = dq_head + 4'd1;
        dq_count--;
      end else begin
        slot = dq_head + dq_count[3:0] - 4'd1;
        r.popped_value = dq_store[slot];
        dq_count--;
      end
    end
    r.occupancy = dq_count;
    return r;
  endfunction

  // Offer one beat, after random idle gaps outside quiet runs; returns at the falling edge after it is taken
  task automatic offer_beat(input dec_in_t beat, input bit typed, input dec_out_t typed_res);
    dec_out_t predicted;
    if (!quiet_run) begin
      while ($urandom_range(99) < 27) begin
        in_valid_i <= 1'b0;
        @(negedge clk_i);
      end
    end
    in_valid_i <= 1'b1;
    in_data_i  <= beat;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    predicted = deque_step(beat);
    exp_results.push_back(typed ? typed_res : predicted);
    @(negedge clk_i);
  endtask

  // Result side back-pressure: random stalls, plus one long hold-off on request
  always @(negedge clk_i) begin
    if (hold_cycles > 0) begin
      out_stall_i <= 1'b1;
      hold_cycles--;
    end else if (hold_req) begin
      hold_req    = 1'b0;
      hold_cycles = 79;
      out_stall_i <= 1'b1;
    end else begin
      out_stall_i <= !quiet_run && ($urandom_range(99) < 27);
    end
  end

  // Compare each result beat against the oldest expectation
  always @(posedge clk_i) begin : check_results
    dec_out_t want;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (exp_results.size() == 0) begin
        $error("result beat with nothing expected: status %0d value %h occ %0d",
               out_data_o.status, out_data_o.popped_value, out_data_o.occupancy);
        errors++;
      end else begin
        want = exp_results.pop_front();
        if (out_data_o.status !== want.status) begin
          $error("status: expected %0d, got %0d", want.status, out_data_o.status);
          errors++;
        end
        if (out_data_o.popped_value !== want.popped_value) begin
          $error("popped_value: expected %h, got %h", want.popped_value,
                 out_data_o.popped_value);
          errors++;
        end
        if (out_data_o.occupancy !== want.occupancy) begin
          $error("occupancy: expected %0d, got %0d", want.occupancy, out_data_o.occupancy);
          errors++;
        end
      end
    end
  end

  // Watchdog
  always @(posedge clk_i) begin
    cycles++;
    if (cycles > CycleLimit) begin
      $display("== FAIL ==");
      $finish;
    end
  end

  initial begin
    dec_in_t  item;
    dec_out_t res;
    int       push_pct;
    push_pct = 50;

    repeat (11) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // Directed table
    foreach (dir_rows[i]) begin
      item.func         = dir_rows[i].func;
      item.push_value   = dir_rows[i].value;
      res.status        = dir_rows[i].st;
      res.popped_value  = dir_rows[i].popped;
      res.occupancy     = dir_rows[i].occ;
      offer_beat(item, dir_rows[i].typed, res);
    end

    // Random ops, push bias changes every 50 beats so the queue swings full and empty
    res = '0;
    for (int n = 0; n < RandomOps; n++) begin
      if (n % 50 == 0) begin
        case ($urandom_range(4))
          0: push_pct = 10;
          1: push_pct = 35;
          2: push_pct = 50;
          3: push_pct = 65;
          default: push_pct = 90;
        endcase
      end
      quiet_run = (n >= 1000 && n < 1200);
      if (n == 300) hold_req = 1'b1;
      // let everything drain once, input side idle
      if (n == 800) begin
        in_valid_i <= 1'b0;
        @(negedge clk_i);
        while (exp_results.size() != 0) @(negedge clk_i);
      end
      if ($urandom_range(99) < push_pct) begin
        item.func = $urandom_range(1) ? FUNC_PUSH_BACK : FUNC_PUSH_FRONT;
      end else begin
        item.func = $urandom_range(1) ? FUNC_POP_BACK : FUNC_POP_FRONT;
      end
      case ($urandom_range(7))
        0: item.push_value = 32'h8000_0000;
        1: item.push_value = 32'h7FFF_FFFF;
        2: item.push_value = 32'h0000_0000;
        3: item.push_value = 32'hFFFF_FFFF;
        default: item.push_value = $urandom();
      endcase
      offer_beat(item, 1'b0, res);
    end
    quiet_run = 1'b0;
    in_valid_i <= 1'b0;

    while (exp_results.size() != 0) @(posedge clk_i);
    repeat (8) @(posedge clk_i);
    if (errors == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
